### rtl/core/slab_buffer_pool_allocator_unit_macros.svh
// assertion macros for the slab allocator
`ifndef SLAB_BUFFER_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define SLAB_BUFFER_POOL_ALLOCATOR_UNIT_MACROS_SVH
// property that holds on every clock edge outside reset
`define SBPA_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// implication checked on every clock edge outside reset
`define SBPA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`endif

### rtl/core/sbpa_pkg.sv
// package: types and constants of the slab allocator
`default_nettype none
package sbpa_pkg;
  localparam int unsigned NumSlabsDef  = 16;
  localparam int unsigned SlabBytesDef = 4096;
  localparam int unsigned LenW   = 13;
  localparam int unsigned IdW    = 4;
  localparam int unsigned StampW = 32;
  localparam int unsigned RefW   = 16;
  localparam int unsigned LimW   = 5;

  typedef enum logic [1:0] {OP_GET = 2'd0, OP_TRIM = 2'd1, OP_REL = 2'd2, OP_NONE = 2'd3} op_e;
  typedef enum logic [1:0] {OWN_FREE = 2'd0, OWN_APP = 2'd1, OWN_INT = 2'd2, OWN_RSV = 2'd3}
    owner_e;
  typedef enum logic [2:0] {ST_OK = 3'd0, ST_TOO_LARGE = 3'd1, ST_APP_LIMIT = 3'd2,
                            ST_NO_FREE = 3'd3, ST_BAD_REL = 3'd4} status_e;
  typedef enum logic [1:0] {CFG_MAX_FRAG = 2'd0, CFG_APP_LIMIT = 2'd1} cfg_idx_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [LenW-1:0] request_length;
    logic            for_app;
    logic            exempt_from_limit;
    logic [IdW-1:0]  slab_id;
    logic [LenW-1:0] buffer_offset;
    logic [LenW-1:0] granted_length;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [IdW-1:0]  granted_slab;
    logic [LenW-1:0] granted_offset;
    logic            slab_freed;
  } rsp_t;

  // one slab as it rides through the ring
  typedef struct packed {
    logic [LenW-1:0]   used;
    logic [RefW-1:0]   refs;
    owner_e            owner;
    logic [StampW-1:0] stamp;
  } slab_t;

  // command record for the ring cells
  typedef struct packed {
    logic              rotate;
    logic              init;
    logic [StampW-1:0] stamp_ctr;
    logic              en;
    logic [1:0]        kind;   // 0 search, 1 write back
    logic [15:0]       tgt;    // slab index under write
    slab_t             wdata;
  } ring_cmd_t;
endpackage
`default_nettype wire

### rtl/core/sbpa_cell.sv
// one slab cell of the rotating ring
`default_nettype none
module sbpa_cell
  import sbpa_pkg::*;
#(
  parameter int unsigned NumSlabs = NumSlabsDef,
  parameter int unsigned IdxW = (NumSlabs > 1) ? $clog2(NumSlabs) : 1,
  parameter int unsigned Pos = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            init_i,
  input  wire logic            shift_i,
  input  wire slab_t           prev_i,
  input  wire logic [IdxW-1:0] prev_idx_i,
  input  wire logic            wr_i,
  input  wire slab_t           wdata_i,
  output      slab_t           slab_o,
  output      logic [IdxW-1:0] idx_o
);
  slab_t slab_q, slab_d;
  logic [IdxW-1:0] idx_q, idx_d;

  always_comb begin
    slab_d = slab_q;
    idx_d  = idx_q;
    if (init_i) begin
      slab_d.used  = '0;
      slab_d.refs  = '0;
      slab_d.owner = OWN_FREE;
      slab_d.stamp = StampW'(Pos);
      idx_d        = IdxW'(Pos);
    end else if (wr_i) begin
      slab_d = wdata_i;
    end else if (shift_i) begin
      slab_d = prev_i;
      idx_d  = prev_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slab_q.used  <= '0;
      slab_q.refs  <= '0;
      slab_q.owner <= OWN_FREE;
      slab_q.stamp <= StampW'(Pos);
      idx_q        <= IdxW'(Pos);
    end else begin
      slab_q <= slab_d;
      idx_q  <= idx_d;
    end
  end

  assign slab_o = slab_q;
  assign idx_o  = idx_q;
endmodule
`default_nettype wire

### rtl/core/slab_buffer_pool_allocator_unit.sv
// top level: slab allocator with a rotating ring of slab cells
// usage
//   start_i with req_i launches one transaction (get, trim or release)
//   busy_o stays high while it is worked on; start is ignored then
//   the result appears on rsp_o for one cycle with done_o high
//   cfg_we_i/cfg_idx_i/cfg_data_i write the two registers, only while idle: a user rule, not enforced
// structure
//   the slab records sit in a ring of NumSlabs cells; each cycle of a search
//   every cell hands its record to its neighbor, and cell 0 is examined
//   a compare unit keeps the newest slab of the class and the oldest free slab
// sequence
//   from accept to result: one full ring rotation for the search, a decision
//   step, rotating the write target into cell 0, and a result step; the next
//   transaction is accepted only once the block is idle again after the
//   result
// reset
//   all slabs free, stamps equal to index, stamp counter NumSlabs,
//   registers to 4096 and 16; no sweep needed, the ring resets at once
// the receiver cannot stall: done_o is a single-cycle strobe
`default_nettype none
module slab_buffer_pool_allocator_unit
  import sbpa_pkg::*;
#(
  parameter int unsigned NumSlabs  = NumSlabsDef,
  parameter int unsigned SlabBytes = SlabBytesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire sbpa_pkg::req_t req_i,
  output      logic          busy_o,
  output      logic          done_o,
  output      sbpa_pkg::rsp_t rsp_o,
  input  wire logic          cfg_we_i,
  input  wire logic [0:0]    cfg_idx_i,
  input  wire logic [12:0]   cfg_data_i
);
  `include "slab_buffer_pool_allocator_unit_macros.svh"

  localparam int unsigned IdxW = (NumSlabs > 1) ? $clog2(NumSlabs) : 1;
  localparam int unsigned CntW = $clog2(NumSlabs + 1);
  localparam logic [LenW:0] SlabCap =
    (SlabBytes > 8191) ? (LenW+1)'(8191) : (LenW+1)'(SlabBytes);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_DEC = 5'b00100,
    S_SEEK = 5'b01000, S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  req_t req_q;
  logic [12:0] max_frag_q;
  logic [LimW-1:0] app_lim_q;
  logic [StampW-1:0] stamp_ctr_q, stamp_ctr_d;
  logic [LimW-1:0] app_cnt_q, app_cnt_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  rsp_t rsp_q, rsp_d;
  // search results
  logic new_vld_q, new_vld_d, old_vld_q, old_vld_d, tgt_vld_q, tgt_vld_d;
  logic [IdxW-1:0] new_idx_q, new_idx_d, old_idx_q, old_idx_d;
  logic [StampW-1:0] new_age_q, new_age_d, old_age_q, old_age_d;
  slab_t new_rec_q, new_rec_d, tgt_rec_q, tgt_rec_d;
  // write back
  logic [IdxW-1:0] wb_idx_q, wb_idx_d;
  slab_t wb_rec_q, wb_rec_d;
  logic wb_en_q, wb_en_d;

  slab_t cell_slab [NumSlabs];
  logic [IdxW-1:0] cell_idx [NumSlabs];
  logic shift, wr0;

  for (genvar g = 0; g < NumSlabs; g++) begin : g_cell
    sbpa_cell #(.NumSlabs(NumSlabs), .IdxW(IdxW), .Pos(g)) u_cell (
      .clk_i, .rst_ni,
      .init_i     (1'b0),
      .shift_i    (shift),
      .prev_i     (cell_slab[(g + 1) % NumSlabs]),
      .prev_idx_i (cell_idx[(g + 1) % NumSlabs]),
      .wr_i       ((g == 0) ? wr0 : 1'b0),
      .wdata_i    (wb_rec_q),
      .slab_o     (cell_slab[g]),
      .idx_o      (cell_idx[g])
    );
  end

  slab_t head;
  logic [IdxW-1:0] head_idx;
  logic [StampW-1:0] head_age;
  owner_e want;
  logic [LenW:0] cap;
  logic [LenW:0] room;
  logic fits;
  assign head     = cell_slab[0];
  assign head_idx = cell_idx[0];
  assign head_age = stamp_ctr_q - head.stamp;
  assign want     = req_q.for_app ? OWN_APP : OWN_INT;
  assign cap      = ({1'b0, max_frag_q} < SlabCap) ? {1'b0, max_frag_q} : SlabCap;
  // writing cell 0 happens at the seek step once the target has rotated to it
  assign wr0   = (state_q == S_SEEK) && wb_en_q && (head_idx == wb_idx_q);
  assign shift = (state_q == S_SCAN) ||
                 ((state_q == S_SEEK) && !(wb_en_q && head_idx == wb_idx_q));

  always_comb begin
    room = ({1'b0, new_rec_q.used} >= cap) ? '0 : cap - {1'b0, new_rec_q.used};
    fits = new_vld_q && (room >= {1'b0, req_q.request_length});
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rsp_d = rsp_q;
    stamp_ctr_d = stamp_ctr_q; app_cnt_d = app_cnt_q;
    new_vld_d = new_vld_q; new_idx_d = new_idx_q; new_age_d = new_age_q;
    new_rec_d = new_rec_q; old_vld_d = old_vld_q; old_idx_d = old_idx_q;
    old_age_d = old_age_q; tgt_vld_d = tgt_vld_q; tgt_rec_d = tgt_rec_q;
    wb_idx_d = wb_idx_q; wb_rec_d = wb_rec_q; wb_en_d = wb_en_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SCAN; cnt_d = '0;
          new_vld_d = 1'b0; old_vld_d = 1'b0; tgt_vld_d = 1'b0;
          rsp_d = '0;
        end
      end
      S_SCAN: begin
        // examine the record now in cell 0, ties keep the lower index
        if (head.owner == want) begin
          if (!new_vld_q || head_age < new_age_q ||
              (head_age == new_age_q && head_idx < new_idx_q)) begin
            new_vld_d = 1'b1; new_idx_d = head_idx; new_age_d = head_age;
            new_rec_d = head;
          end
        end
        if (head.owner == OWN_FREE) begin
          if (!old_vld_q || head_age > old_age_q ||
              (head_age == old_age_q && head_idx < old_idx_q)) begin
            old_vld_d = 1'b1; old_idx_d = head_idx; old_age_d = head_age;
          end
        end
        if ({{(16-IdxW){1'b0}}, head_idx} == {12'd0, req_q.slab_id}) begin
          tgt_vld_d = 1'b1; tgt_rec_d = head;
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(NumSlabs - 1)) state_d = S_DEC;
      end
      S_DEC: begin
        wb_en_d = 1'b0;
        wb_rec_d = tgt_rec_q;
        wb_idx_d = req_q.slab_id[IdxW-1:0];
        unique case (op_e'(req_q.operation))
          OP_GET: begin
            if ({1'b0, req_q.request_length} > cap) begin
              rsp_d.status = ST_TOO_LARGE;
            end else if (fits) begin
              wb_en_d = 1'b1; wb_idx_d = new_idx_q; wb_rec_d = new_rec_q;
              if (new_rec_q.refs != '1) wb_rec_d.refs = new_rec_q.refs + RefW'(1);
              wb_rec_d.used = new_rec_q.used + req_q.request_length;
              rsp_d.granted_slab   = IdW'(new_idx_q);
              rsp_d.granted_offset = new_rec_q.used;
            end else if (req_q.for_app && !req_q.exempt_from_limit &&
                         app_cnt_q >= app_lim_q) begin
              rsp_d.status = ST_APP_LIMIT;
            end else if (!old_vld_q) begin
              rsp_d.status = ST_NO_FREE;
            end else begin
              wb_en_d = 1'b1; wb_idx_d = old_idx_q;
              wb_rec_d.owner = want;
              wb_rec_d.used  = req_q.request_length;
              wb_rec_d.refs  = RefW'(1);
              wb_rec_d.stamp = stamp_ctr_q;
              stamp_ctr_d = stamp_ctr_q + StampW'(1);
              if (req_q.for_app) app_cnt_d = app_cnt_q + LimW'(1);
              rsp_d.granted_slab   = IdW'(old_idx_q);
              rsp_d.granted_offset = '0;
            end
          end
          OP_TRIM: begin
            if (tgt_vld_q && tgt_rec_q.owner != OWN_FREE &&
                req_q.request_length <= req_q.granted_length &&
                ({1'b0, req_q.buffer_offset} + {1'b0, req_q.granted_length}) ==
                {1'b0, tgt_rec_q.used}) begin
              wb_en_d = 1'b1;
              wb_rec_d.used = req_q.buffer_offset + req_q.request_length;
            end
          end
          OP_REL: begin
            if (!tgt_vld_q || tgt_rec_q.owner == OWN_FREE || tgt_rec_q.refs == '0) begin
              rsp_d.status = ST_BAD_REL;
            end else begin
              wb_en_d = 1'b1;
              wb_rec_d.refs = tgt_rec_q.refs - RefW'(1);
              if (tgt_rec_q.refs == RefW'(1)) begin
                if (tgt_rec_q.owner == OWN_APP && app_cnt_q != '0)
                  app_cnt_d = app_cnt_q - LimW'(1);
                wb_rec_d.owner = OWN_FREE;
                wb_rec_d.stamp = stamp_ctr_q;
                stamp_ctr_d = stamp_ctr_q + StampW'(1);
                rsp_d.slab_freed = 1'b1;
              end
            end
          end
          default: ;
        endcase
        cnt_d = '0;
        state_d = S_SEEK;
      end
      S_SEEK: begin
        // rotate until the write target sits in cell 0, at most one round
        cnt_d = cnt_q + CntW'(1);
        if (!wb_en_q || head_idx == wb_idx_q) state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0;
      max_frag_q <= 13'd4096; app_lim_q <= LimW'(16);
      stamp_ctr_q <= StampW'(NumSlabs); app_cnt_q <= '0;
      new_vld_q <= 1'b0; old_vld_q <= 1'b0; tgt_vld_q <= 1'b0; wb_en_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
      stamp_ctr_q <= stamp_ctr_d; app_cnt_q <= app_cnt_d;
      new_vld_q <= new_vld_d; old_vld_q <= old_vld_d; tgt_vld_q <= tgt_vld_d;
      wb_en_q <= wb_en_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'(CFG_MAX_FRAG)) max_frag_q <= cfg_data_i;
        else app_lim_q <= cfg_data_i[LimW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) req_q <= req_i;
    rsp_q <= rsp_d;
    new_idx_q <= new_idx_d; new_age_q <= new_age_d; new_rec_q <= new_rec_d;
    old_idx_q <= old_idx_d; old_age_q <= old_age_d; tgt_rec_q <= tgt_rec_d;
    wb_idx_q <= wb_idx_d; wb_rec_q <= wb_rec_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign rsp_o  = rsp_q;

  `SBPA_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `SBPA_ASSERT_IMPL(a_done_after_seek, clk_i, rst_ni, done_o, $past(state_q == S_SEEK),
                    "done without seek")
  `SBPA_ASSERT(a_app_cnt, clk_i, rst_ni, app_cnt_q <= LimW'(NumSlabs), "app count overflow")
  `SBPA_ASSERT_IMPL(a_no_shift_idle, clk_i, rst_ni, state_q == S_IDLE, !shift,
                    "ring moved while idle")
endmodule
`default_nettype wire

### bench/slab_allocator_checker.sv
// checker: watches the request and result channels and predicts every result
`timescale 1ns / 100ps
`default_nettype none
module slab_allocator_checker
  import sbpa_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           busy_i,
  input  wire sbpa_pkg::req_t req_i,
  input  wire logic           done_i,
  input  wire sbpa_pkg::rsp_t rsp_i,
  input  wire logic           cfg_we_i,
  input  wire logic [0:0]     cfg_idx_i,
  input  wire logic [12:0]    cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);
  localparam int unsigned Slabs = NumSlabsDef;

  logic [LenW-1:0]   frag_size;
  logic [LimW-1:0]   app_limit;
  logic [LenW-1:0]   used_q  [Slabs];
  logic [RefW-1:0]   refs_q  [Slabs];
  owner_e            owner_q [Slabs];
  logic [StampW-1:0] stamp_q [Slabs];
  logic [StampW-1:0] stamp_ctr;
  logic [LimW-1:0]   app_count;
  rsp_t              expected_rsp_q[$];

  function automatic int pick(owner_e own, bit oldest);
    int best;
    logic [StampW-1:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < Slabs; i++) begin
      if (owner_q[i] == own) begin
        age = stamp_ctr - stamp_q[i];
        if (best < 0 || (oldest ? age > best_age : age < best_age)) begin
          best = i;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic void bump_stamp(int i);
    stamp_q[i] = stamp_ctr;
    stamp_ctr = stamp_ctr + 1;
  endfunction

  // one transaction through the slab pool model
  function automatic rsp_t allocate(req_t r);
    rsp_t   res;
    int     s;
    int     cap, room;
    bit     fits;
    owner_e own;
    res = '0;
    res.status = ST_OK;
    case (op_e'(r.operation))
      OP_GET: begin
        cap = (frag_size < SlabBytesDef) ? int'(frag_size) : SlabBytesDef;
        own = r.for_app ? OWN_APP : OWN_INT;
        if (int'(r.request_length) > cap) begin
          res.status = ST_TOO_LARGE;
        end else begin
          s = pick(own, 1'b0);
          fits = 1'b0;
          if (s >= 0) begin
            room = (int'(used_q[s]) >= cap) ? 0 : cap - int'(used_q[s]);
            fits = room >= int'(r.request_length);
          end
          if (!fits) begin
            if (r.for_app && !r.exempt_from_limit && app_count >= app_limit) begin
              res.status = ST_APP_LIMIT;
              s = -1;
            end else begin
              s = pick(OWN_FREE, 1'b1);
              if (s < 0) begin
                res.status = ST_NO_FREE;
              end else begin
                owner_q[s] = own;
                used_q[s] = '0;
                refs_q[s] = '0;
                bump_stamp(s);
                if (r.for_app) app_count = app_count + 1;
              end
            end
          end
          if (res.status == ST_OK && s >= 0) begin
            if (refs_q[s] != '1) refs_q[s] = refs_q[s] + 1;
            res.granted_slab = s[IdW-1:0];
            res.granted_offset = used_q[s];
            used_q[s] = used_q[s] + r.request_length;
          end
        end
      end
      OP_TRIM: begin
        if (owner_q[r.slab_id] != OWN_FREE && r.request_length <= r.granted_length &&
            14'(r.buffer_offset) + 14'(r.granted_length) == 14'(used_q[r.slab_id]))
          used_q[r.slab_id] = r.buffer_offset + r.request_length;
      end
      OP_REL: begin
        s = r.slab_id;
        if (owner_q[s] == OWN_FREE || refs_q[s] == 0) begin
          res.status = ST_BAD_REL;
        end else begin
          refs_q[s] = refs_q[s] - 1;
          if (refs_q[s] == 0) begin
            if (owner_q[s] == OWN_APP && app_count > 0) app_count = app_count - 1;
            owner_q[s] = OWN_FREE;
            bump_stamp(s);
            res.slab_freed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  assign pending_o = expected_rsp_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      frag_size = 13'd4096;
      app_limit = 5'd16;
      for (int i = 0; i < Slabs; i++) begin
        used_q[i] = '0;
        refs_q[i] = '0;
        owner_q[i] = OWN_FREE;
        stamp_q[i] = StampW'(i);
      end
      stamp_ctr = StampW'(Slabs);
      app_count = '0;
      expected_rsp_q.delete();
      errors_o <= 0;
    end else begin
      // result first: a new transaction cannot finish in the cycle it starts
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_i !== exp_rsp) begin
            $display("%0t: result mismatch expected %p actual %p", $time, exp_rsp, rsp_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MAX_FRAG) frag_size = cfg_data_i;
        else app_limit = cfg_data_i[LimW-1:0];
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(allocate(req_i));
    end
  end
endmodule
`default_nettype wire

### bench/testbench.sv
// testbench top: stimulus for the slab allocator and the verdict
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import sbpa_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ReqW = $bits(req_t);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  req_t        req = '0;
  logic        busy, done;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_idx = '0;
  logic [12:0] cfg_data = '0;
  int          errors, pending;
  int          cycles = 0;
  int          idle_pct = 0;
  // slabs that hold live buffers, so releases hit real ones; trims use the last grant
  logic [3:0]  live_slab_q[$];
  logic [12:0] last_off = '0;
  logic [12:0] last_len;
  logic [3:0]  last_slab = '0;

  always #5 clk = ~clk;

  slab_buffer_pool_allocator_unit DUT (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .req_i(req), .busy_o(busy),
    .done_o(done), .rsp_o(rsp), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  slab_allocator_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .req_i(req),
    .done_i(done), .rsp_i(rsp), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .errors_o(errors), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // remember granted buffers so later trims and releases are well formed
  always @(posedge clk) begin
    if (done && rsp.status == ST_OK && rsp.slab_freed == 1'b0 && last_len != 13'h1fff) begin
      live_slab_q.push_back(rsp.granted_slab);
      last_slab <= rsp.granted_slab;
      last_off <= rsp.granted_offset;
    end
  end

  // hand one transaction over and await its result, holding start until then
  task automatic issue(input req_t r);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    while (!done) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
    req <= '0;
  endtask

  task automatic get(input logic [12:0] len, input bit app, input bit exempt);
    req_t r;
    r = '0;
    r.operation = OP_GET;
    r.request_length = len;
    r.for_app = app;
    r.exempt_from_limit = exempt;
    last_len = (r.operation == OP_GET) ? len : 13'h1fff;
    issue(r);
  endtask

  task automatic other(input op_e op, input logic [3:0] sid, input logic [12:0] len,
                       input logic [12:0] boff, input logic [12:0] glen);
    req_t r;
    r = req_t'(ReqW'({$urandom, $urandom}));
    r.operation = op;
    r.slab_id = sid;
    r.request_length = len;
    r.buffer_offset = boff;
    r.granted_length = glen;
    last_len = 13'h1fff;
    issue(r);
  endtask

  // quiet point, then register write
  task automatic write_cfg(input cfg_idx_e idx, input logic [12:0] val);
    while (pending != 0 || busy) @(negedge clk);
    repeat (24) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx[0:0];
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int sel, k;
    logic [3:0] sid;
    sel = $urandom_range(99);
    if (live_slab_q.size() > 0) begin
      k = $urandom_range(live_slab_q.size() - 1);
      sid = live_slab_q[k];
    end else begin
      k = -1;
      sid = 4'($urandom);
    end
    if (sel < 45) begin
      // mostly small gets, sometimes anything
      get(($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(600)),
          1'($urandom), $urandom_range(3) == 0);
    end else if (sel < 75) begin
      if (k >= 0) live_slab_q.delete(k);
      other(OP_REL, ($urandom_range(9) == 0) ? 4'($urandom) : sid, 13'($urandom),
            13'($urandom), 13'($urandom));
    end else if (sel < 90) begin
      // trim of the newest carve, sometimes broken
      other(OP_TRIM, last_slab, 13'($urandom_range(last_len == 13'h1fff ? 0 : 300)),
            last_off, ($urandom_range(4) == 0) ? 13'($urandom) : 13'($urandom_range(300)));
    end else if (sel < 95) begin
      other(OP_NONE, 4'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
    end else begin
      other(OP_TRIM, 4'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
    end
  endtask

  initial begin
    last_len = 13'h1fff;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every operation, special cases
    get(13'd4097, 1'b1, 1'b0);               // too large
    get(13'h1fff, 1'b0, 1'b0);
    get(13'd4096, 1'b1, 1'b0);               // whole slab
    get(13'd0, 1'b1, 1'b0);                  // zero length fits a full slab
    get(13'd100, 1'b0, 1'b1);
    other(OP_TRIM, last_slab, 13'd40, last_off, 13'd100);
    other(OP_TRIM, last_slab, 13'd50, last_off, 13'd40);  // length over granted
    other(OP_REL, 4'd15, '0, '0, '0);        // free slab
    other(OP_NONE, 4'd3, 13'h1fff, 13'h1fff, 13'h1fff);
    for (int i = 0; i < 17; i++) get(13'd4096, 1'b0, 1'b0);  // pool runs dry
    write_cfg(CFG_APP_LIMIT, 13'd0);
    get(13'd10, 1'b1, 1'b0);                 // app limit
    get(13'd10, 1'b1, 1'b1);
    for (int s = 0; s < 16; s++) other(OP_REL, s[3:0], '0, '0, '0);
    other(OP_REL, 4'd0, '0, '0, '0);         // references reach zero, slab freed
    write_cfg(CFG_MAX_FRAG, 13'd0);
    get(13'd0, 1'b0, 1'b0);
    get(13'd1, 1'b0, 1'b0);
    live_slab_q.delete();
    for (int s = 0; s < 16; s++) other(OP_REL, s[3:0], '0, '0, '0);

    // random phases with differing settings and idling
    for (int ph = 0; ph < 12; ph++) begin
      write_cfg(CFG_MAX_FRAG, (ph % 4 == 0) ? 13'd4096 : (ph % 4 == 1) ? 13'h1fff :
                13'($urandom_range(4096)));
      write_cfg(CFG_APP_LIMIT, (ph % 3 == 0) ? 13'd16 : (ph % 3 == 1) ? 13'd31 :
                13'($urandom_range(16)));
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 65;
        2: idle_pct = 0;
        default: idle_pct = 6;
      endcase
      for (int n = 0; n < 160; n++) random_item();
    end

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
